### rtl/core/div64_pkg.sv
// Shared widths and types for the 64-by-32 divider.
package div64_pkg;

  localparam int unsigned DvdW = 64;
  localparam int unsigned DvsW = 32;
  localparam int unsigned CntW = $clog2(DvdW);

  localparam logic KindUnsigned = 1'b0;
  localparam logic KindSigned   = 1'b1;

  typedef struct packed {
    logic [DvdW-1:0] quo;
    logic [DvsW-1:0] rem;
  } div64_res_t;

endpackage

### rtl/core/div64_recur.sv
// Radix-2 restoring recurrence: one quotient bit per cycle through a shift register.
module div64_recur (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [div64_pkg::DvdW-1:0]  dividend_i,
  input  logic [div64_pkg::DvsW-1:0]  divisor_i,
  output logic                        done_o,
  output div64_pkg::div64_res_t       res_o
);
  import div64_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DvdW-1:0]     shq_q, shq_d;
  logic [DvsW-1:0]     rem_q, rem_d;
  logic [DvsW-1:0]     dvs_q, dvs_d;
  logic [DvsW:0]       trial;
  logic [DvsW:0]       diff;
  logic                ge;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign trial = {rem_q, shq_q[DvdW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shq_d  = shq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      shq_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      shq_d = {shq_q[DvdW-2:0], ge};
      rem_d = ge ? diff[DvsW-1:0] : trial[DvsW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shq_q <= shq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o    = done_q;
  assign res_o.quo = shq_q;
  assign res_o.rem = rem_q;

endmodule

### rtl/core/divide_64_by_32_core.sv
// Top level of the 64-by-32 signed/unsigned integer divider.
// Sequence: take magnitudes (StPrep), run the one-bit-per-cycle recurrence (StRun) until its
// done flag, then restore signs (StFix) and write the output register once it is free;
// a zero divisor skips the recurrence and goes straight to StFix.
// A new request is accepted only once the current one has left StFix and the core is idle.
// Reset: rst_ni asynchronous, active low; clears control state and output valid.
module divide_64_by_32_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [div64_pkg::DvdW-1:0]  dividend_i,
  input  logic [div64_pkg::DvsW-1:0]  divisor_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [div64_pkg::DvdW-1:0]  quotient_o,
  output logic [div64_pkg::DvsW-1:0]  remainder_o,
  output logic                        divide_by_zero_o
);
  import div64_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;
  localparam logic [1:0] StFix  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic             qneg_q, qneg_d;    // quotient must be negated
  logic             rneg_q, rneg_d;    // remainder must be negated
  logic             dz_q, dz_d;
  logic [DvdW-1:0]  dvd_q, dvd_d;
  logic [DvsW-1:0]  dvs_q, dvs_d;

  logic             out_valid_q, out_valid_d;
  logic [DvdW-1:0]  out_quo_q, out_quo_d;
  logic [DvsW-1:0]  out_rem_q, out_rem_d;
  logic             out_dz_q, out_dz_d;

  logic             in_acc;
  logic             out_free;
  logic             rec_start;
  logic             rec_done;
  div64_res_t       rec_res;
  logic             sgn;
  logic             num_neg;
  logic             den_neg;
  logic [DvdW-1:0]  dvd_mag;
  logic [DvsW-1:0]  dvs_mag;

  // Magnitude conversion feeds the recurrence directly from the captured operands.
  assign dvd_mag = rneg_q ? (DvdW'(0) - dvd_q) : dvd_q;
  assign dvs_mag = (qneg_q ^ rneg_q) ? (DvsW'(0) - dvs_q) : dvs_q;

  div64_recur u_recur (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rec_start),
    .dividend_i (dvd_mag),
    .divisor_i  (dvs_mag),
    .done_o     (rec_done),
    .res_o      (rec_res)
  );

  // Hold off new requests until the current one has left the fixup stage.
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  // Output register frees up when empty or when its result is taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rec_start  = (state_q == StPrep);

  assign sgn     = (kind_i == KindSigned);
  assign num_neg = sgn && dividend_i[DvdW-1];
  assign den_neg = sgn && divisor_i[DvsW-1];

  always_comb begin
    state_d     = state_q;
    qneg_d      = qneg_q;
    rneg_d      = rneg_q;
    dz_d        = dz_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_quo_d   = out_quo_q;
    out_rem_d   = out_rem_q;
    out_dz_d    = out_dz_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          // Capture raw operands; a zero divisor jumps straight to the fallback.
          dvd_d   = dividend_i;
          dvs_d   = divisor_i;
          qneg_d  = num_neg ^ den_neg;
          rneg_d  = num_neg;
          dz_d    = (divisor_i == '0);
          state_d = (divisor_i == '0) ? StFix : StPrep;
        end
      end
      StPrep: begin
        // Take magnitudes; the recurrence latches them this same edge.
        state_d = StRun;
      end
      StRun: begin
        if (rec_done) begin
          state_d = StFix;
        end
      end
      StFix: begin
        // Restore signs, or form the divide-by-zero result, and drop it into the output register when free.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dz_d    = dz_q;
          if (dz_q) begin
            out_quo_d = '1;
            out_rem_d = dvd_q[DvsW-1:0];
          end else begin
            out_quo_d = qneg_q ? (DvdW'(0) - rec_res.quo) : rec_res.quo;
            out_rem_d = rneg_q ? (DvsW'(0) - rec_res.rem) : rec_res.rem;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Advance operand and output registers.
  always_ff @(posedge clk_i) begin
    qneg_q    <= qneg_d;
    rneg_q    <= rneg_d;
    dz_q      <= dz_d;
    dvd_q     <= dvd_d;
    dvs_q     <= dvs_d;
    out_quo_q <= out_quo_d;
    out_rem_q <= out_rem_d;
    out_dz_q  <= out_dz_d;
  end

  assign out_valid_o      = out_valid_q;
  assign quotient_o       = out_quo_q;
  assign remainder_o      = out_rem_q;
  assign divide_by_zero_o = out_dz_q;

endmodule
